FILE: src/trd_pkg.sv
// Shared types and constants for the telemetry ring with decimation.
// No dependencies.
package trd_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_FINE_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COARSE_STRIDE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ABSENCE_LIMIT = 2'd2;

  localparam logic [15:0] FINE_INTERVAL_RST = 16'd1000;
  localparam logic [4:0]  COARSE_STRIDE_RST = 5'd2;
  localparam logic [31:0] ABSENCE_LIMIT_RST = 32'd1200000;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef struct packed {
    logic [31:0] seq;
    logic [31:0] time_ms;
    logic [63:0] data;
  } rec_t;

  typedef struct packed {
    logic        stored;
    logic [31:0] stored_seq;
    logic        coarse_mode;
    logic [10:0] entry_count;
    logic        read_valid;
    logic [31:0] read_seq;
    logic [31:0] read_time_ms;
    logic [63:0] read_data;
  } res_t;

endpackage

FILE: src/trd_if.sv
// Valid/ready channel interfaces for input items and result items.
// Depends on nothing.
interface trd_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] now_ms;
  logic [31:0] client_seen_ms;
  logic [63:0] record_data;
  logic [9:0]  read_index;
  modport source (output valid, func, now_ms, client_seen_ms, record_data, read_index,
                  input ready);
  modport sink   (input valid, func, now_ms, client_seen_ms, record_data, read_index,
                  output ready);
endinterface

interface trd_out_if;
  logic        valid;
  logic        ready;
  logic        stored;
  logic [31:0] stored_seq;
  logic        coarse_mode;
  logic [10:0] entry_count;
  logic        read_valid;
  logic [31:0] read_seq;
  logic [31:0] read_time_ms;
  logic [63:0] read_data;
  modport source (output valid, stored, stored_seq, coarse_mode, entry_count, read_valid,
                  read_seq, read_time_ms, read_data, input ready);
  modport sink   (input valid, stored, stored_seq, coarse_mode, entry_count, read_valid,
                  read_seq, read_time_ms, read_data, output ready);
endinterface

FILE: src/telemetry_ring_with_decimation_unit.sv
// Telemetry ring with decimation: top level with sequencer and record RAM.
// Depends on trd_pkg, trd_if and trd_ram.
//
// One item is handled at a time. A tick passes through S_EVAL and S_TICK, a read that hits a
// stored record through S_EVAL, S_RD and S_RDD, and a read at or beyond the count through
// S_EVAL alone, before the result is formed for S_OUT. The result then sits in an output
// register while the next item is taken; a finished result waits in the sequencer while that
// register is still full. A tick that thins the store first forms the bit-serial quotient and
// remainder of the thinning offset in S_DIV, sets up the copy in S_CRD, then does one S_CRD
// read and one S_CWR write per kept record through the single record RAM. Records live in that
// RAM with no reset; no clearing pass.
module telemetry_ring_with_decimation_unit #(
  parameter int DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [trd_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [trd_pkg::CFG_W-1:0]     cfg_wdata,
  trd_in_if.sink                        in_ch,
  trd_out_if.source                     out_ch
);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int WW = ((CW > 10) ? CW : 10) + 1;
  localparam logic [WW-1:0] DEPTH_W = WW'(DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_EVAL, S_DIV, S_CRD, S_CWR, S_TICK, S_RD, S_RDD, S_OUT
  } state_t;

  state_t state_r;

  logic [15:0] fine_r;
  logic [4:0]  stride_cfg_r;
  logic [31:0] limit_r;

  logic        func_r;
  logic [31:0] now_r, seen_r;
  logic [63:0] data_r;
  logic [9:0]  ridx_r;

  logic [AW-1:0] ws_r, base_r, slot_r;
  logic [CW-1:0] count_r, quo_r, kept_r, k_r, src_off_r, it_r;
  logic [4:0]    rem_r;
  logic [31:0]   seq_r, last_r, absent_r;
  logic          coarse_r;

  trd_pkg::res_t res_r, outp_r;
  logic          out_valid_r;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  trd_pkg::rec_t        mem_wdata, mem_rdata;

  trd_ram #(.WIDTH($bits(trd_pkg::rec_t)), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  function automatic logic [AW-1:0] wrap(input logic [WW-1:0] a);
    logic [WW-1:0] r;
    r = (a >= DEPTH_W) ? a - DEPTH_W : a;
    return r[AW-1:0];
  endfunction

  logic [4:0]    stride;
  logic [31:0]   absent;
  logic [AW-1:0] oldest;
  logic [WW-1:0] ridx_w, count_w;
  logic [5:0]    rem_sh;
  logic          coarse_eff;
  logic [20:0]   interval;
  logic          do_store;
  logic [31:0]   seq_inc;
  logic [31:0]   cnt32, cnt_store32;
  logic [CW-1:0] count_store;
  logic          out_load;

  always_comb begin
    stride      = (stride_cfg_r == 5'd0) ? 5'd1 : stride_cfg_r;
    absent      = now_r - seen_r;
    count_w     = WW'(count_r);
    ridx_w      = WW'(ridx_r);
    oldest      = wrap(WW'(ws_r) + DEPTH_W - count_w);
    rem_sh      = {rem_r, quo_r[CW-1]};
    coarse_eff  = coarse_r && !(absent_r < {15'd0, fine_r, 1'b0});
    interval    = coarse_eff ? 21'(stride) * 21'(fine_r) : {5'd0, fine_r};
    do_store    = (last_r == 32'd0) || ((now_r - last_r) >= {11'd0, interval});
    seq_inc     = seq_r + 32'd1;
    count_store = (count_w < DEPTH_W) ? count_r + CW'(1) : count_r;
    cnt32       = 32'(count_r);
    cnt_store32 = 32'(do_store ? count_store : count_r);
    out_load    = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

    mem_raddr = (state_r == S_CRD) ? wrap(WW'(base_r) + WW'(src_off_r)) : slot_r;
    mem_we    = 1'b0;
    mem_waddr = ws_r;
    mem_wdata = mem_rdata;
    if (state_r == S_CWR) begin
      mem_we    = 1'b1;
      mem_waddr = wrap(WW'(base_r) + WW'(k_r));
    end else if (state_r == S_TICK) begin
      mem_we    = do_store;
      mem_wdata = '{seq: seq_inc, time_ms: now_r, data: data_r};
    end
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.stored       = outp_r.stored;
  assign out_ch.stored_seq   = outp_r.stored_seq;
  assign out_ch.coarse_mode  = outp_r.coarse_mode;
  assign out_ch.entry_count  = outp_r.entry_count;
  assign out_ch.read_valid   = outp_r.read_valid;
  assign out_ch.read_seq     = outp_r.read_seq;
  assign out_ch.read_time_ms = outp_r.read_time_ms;
  assign out_ch.read_data    = outp_r.read_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fine_r       <= trd_pkg::FINE_INTERVAL_RST;
      stride_cfg_r <= trd_pkg::COARSE_STRIDE_RST;
      limit_r      <= trd_pkg::ABSENCE_LIMIT_RST;
      ws_r         <= '0;
      count_r      <= '0;
      seq_r        <= '0;
      last_r       <= '0;
      coarse_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          trd_pkg::CFG_FINE_INTERVAL: fine_r       <= cfg_wdata[15:0];
          trd_pkg::CFG_COARSE_STRIDE: stride_cfg_r <= cfg_wdata[4:0];
          trd_pkg::CFG_ABSENCE_LIMIT: limit_r      <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            func_r  <= in_ch.func;
            now_r   <= in_ch.now_ms;
            seen_r  <= in_ch.client_seen_ms;
            data_r  <= in_ch.record_data;
            ridx_r  <= in_ch.read_index;
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          absent_r <= absent;
          base_r   <= oldest;
          slot_r   <= wrap(WW'(oldest) + ridx_w);
          res_r    <= '{stored: 1'b0, stored_seq: 32'd0, coarse_mode: coarse_r,
                        entry_count: cnt32[10:0], read_valid: 1'b0, read_seq: 32'd0,
                        read_time_ms: 32'd0, read_data: 64'd0};
          if (func_r == trd_pkg::FUNC_READ) begin
            state_r <= (ridx_w < count_w) ? S_RD : S_OUT;
          end else if (!coarse_r && absent > limit_r && count_r != '0) begin
            quo_r   <= count_r - CW'(1);
            rem_r   <= '0;
            it_r    <= '0;
            state_r <= S_DIV;
          end else begin
            state_r <= S_TICK;
          end
        end
        S_DIV: begin
          quo_r <= {quo_r[CW-2:0], (rem_sh >= {1'b0, stride})};
          rem_r <= (rem_sh >= {1'b0, stride}) ? 5'(rem_sh - {1'b0, stride}) : rem_sh[4:0];
          it_r  <= it_r + CW'(1);
          if (it_r == CW'(CW - 1)) begin
            state_r <= S_CRD;
          end
        end
        S_CRD: begin
          if (k_r == '0 && state_r == S_CRD && it_r != '0) begin
            kept_r    <= quo_r + CW'(1);
            src_off_r <= CW'(rem_r);
            it_r      <= '0;
          end else begin
            state_r <= S_CWR;
          end
        end
        S_CWR: begin
          src_off_r <= src_off_r + CW'(stride);
          if (k_r + CW'(1) == kept_r) begin
            count_r  <= kept_r;
            ws_r     <= wrap(WW'(base_r) + WW'(kept_r));
            last_r   <= mem_rdata.time_ms;
            coarse_r <= 1'b1;
            k_r      <= '0;
            state_r  <= S_TICK;
          end else begin
            k_r     <= k_r + CW'(1);
            state_r <= S_CRD;
          end
        end
        S_TICK: begin
          coarse_r <= coarse_eff;
          res_r    <= '{stored: do_store, stored_seq: (do_store ? seq_inc : 32'd0),
                        coarse_mode: coarse_eff, entry_count: cnt_store32[10:0],
                        read_valid: 1'b0, read_seq: 32'd0, read_time_ms: 32'd0,
                        read_data: 64'd0};
          if (do_store) begin
            last_r  <= now_r;
            seq_r   <= seq_inc;
            ws_r    <= wrap(WW'(ws_r) + WW'(1));
            count_r <= count_store;
          end
          state_r <= S_OUT;
        end
        S_RD: begin
          state_r <= S_RDD;
        end
        S_RDD: begin
          res_r   <= '{stored: 1'b0, stored_seq: 32'd0, coarse_mode: res_r.coarse_mode,
                       entry_count: res_r.entry_count, read_valid: 1'b1,
                       read_seq: mem_rdata.seq, read_time_ms: mem_rdata.time_ms,
                       read_data: mem_rdata.data};
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            outp_r  <= res_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (state_r == S_EVAL) begin
        k_r <= '0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'(DEPTH))
    else $error("entry count above depth");
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(ws_r) < 32'(DEPTH))
    else $error("write slot out of range");
  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_CWR || state_r == S_TICK))
    else $error("record RAM written outside copy or tick");
  a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> state_r == S_EVAL)
    else $error("accepted transaction not evaluated");
`endif
endmodule

FILE: src/trd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module trd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: test/tb_stim_if.sv
`timescale 1ns / 100ps
// Testbench item type for the input channel of the telemetry ring.
// Depends on nothing.
package tb_trd_types;

  typedef struct packed {
    logic        func;
    logic [31:0] now_ms;
    logic [31:0] client_seen_ms;
    logic [63:0] record_data;
    logic [9:0]  read_index;
  } tick_item_t;
endpackage

FILE: test/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for telemetry_ring_with_decimation_unit: directed and random ticks
// and reads, with a ring-store predictor checked against every result transaction.
// Depends on trd_pkg, trd_if, the DUT and tb_trd_types.
module tb;

  localparam int RING_DEPTH = 1024;
  localparam int STALL_LIMIT = 20000;
  localparam logic [trd_pkg::CFG_IDX_W-1:0] CFG_IDX_NONE = 2'd3;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [trd_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [trd_pkg::CFG_W-1:0] cfg_wdata;

  trd_in_if in_ch ();
  trd_out_if out_ch ();

  telemetry_ring_with_decimation_unit #(.DEPTH(RING_DEPTH)) i_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // predictor state
  logic [63:0] ring_data [RING_DEPTH];
  logic [31:0] ring_time [RING_DEPTH];
  logic [31:0] ring_seq [RING_DEPTH];
  int unsigned wr_slot, rec_count;
  logic [31:0] seq_next_base, last_cap;
  logic coarse_on;
  logic [15:0] fine_ms;
  logic [4:0] stride_reg;
  logic [31:0] absent_limit;

  tb_trd_types::tick_item_t pending_items[$];
  trd_pkg::res_t expected_results[$];
  int errors;
  int send_idle_pct, recv_idle_pct;
  bit hold_go, hold_recv, hold_done;
  int in_flight_items;
  logic [31:0] sim_now;

  function automatic int unsigned eff_stride();
    return (stride_reg == 0) ? 1 : stride_reg;
  endfunction

  function automatic int unsigned oldest_slot();
    return (wr_slot + RING_DEPTH - rec_count) % RING_DEPTH;
  endfunction

  task automatic thin_ring();
    int unsigned s, base, kept, first, src, dst;
    s = eff_stride();
    if (rec_count == 0) return;
    base = oldest_slot();
    kept = (rec_count + s - 1) / s;
    first = (rec_count - 1) - (kept - 1) * s;
    for (int k = 0; k < kept; k++) begin
      src = (base + first + k * s) % RING_DEPTH;
      dst = (base + k) % RING_DEPTH;
      ring_data[dst] = ring_data[src];
      ring_time[dst] = ring_time[src];
      ring_seq[dst] = ring_seq[src];
    end
    rec_count = kept;
    wr_slot = (base + kept) % RING_DEPTH;
    last_cap = ring_time[(base + kept - 1) % RING_DEPTH];
    coarse_on = 1'b1;
  endtask

  task automatic predict_ring(input tb_trd_types::tick_item_t it);
    trd_pkg::res_t r;
    logic [31:0] absent, interval, two_fine;
    int unsigned slot;
    r = '0;
    if (it.func == trd_pkg::FUNC_TICK) begin
      absent = it.now_ms - it.client_seen_ms;
      if (!coarse_on && absent > absent_limit) thin_ring();
      two_fine = 32'(fine_ms) * 2;
      if (coarse_on && absent < two_fine) coarse_on = 1'b0;
      interval = coarse_on ? 32'(eff_stride()) * 32'(fine_ms) : 32'(fine_ms);
      if (!(last_cap != 0 && (it.now_ms - last_cap) < interval)) begin
        last_cap = it.now_ms;
        seq_next_base = seq_next_base + 1;
        ring_data[wr_slot] = it.record_data;
        ring_time[wr_slot] = it.now_ms;
        ring_seq[wr_slot] = seq_next_base;
        wr_slot = (wr_slot + 1) % RING_DEPTH;
        if (rec_count < RING_DEPTH) rec_count++;
        r.stored = 1'b1;
        r.stored_seq = seq_next_base;
      end
    end else if (it.read_index < rec_count) begin
      slot = (oldest_slot() + it.read_index) % RING_DEPTH;
      r.read_valid = 1'b1;
      r.read_seq = ring_seq[slot];
      r.read_time_ms = ring_time[slot];
      r.read_data = ring_data[slot];
    end
    r.coarse_mode = coarse_on;
    r.entry_count = 11'(rec_count);
    expected_results.push_back(r);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_ring({in_ch.func, in_ch.now_ms, in_ch.client_seen_ms, in_ch.record_data,
                      in_ch.read_index});
        in_flight_items = in_flight_items - 1;
      end
      if ((!in_ch.valid || in_ch.ready)) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          tb_trd_types::tick_item_t it;
          it = pending_items.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.func <= it.func;
          in_ch.now_ms <= it.now_ms;
          in_ch.client_seen_ms <= it.client_seen_ms;
          in_ch.record_data <= it.record_data;
          in_ch.read_index <= it.read_index;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        trd_pkg::res_t got, exp_r;
        got = {out_ch.stored, out_ch.stored_seq, out_ch.coarse_mode, out_ch.entry_count,
               out_ch.read_valid, out_ch.read_seq, out_ch.read_time_ms, out_ch.read_data};
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction");
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (got.stored !== exp_r.stored) begin
            $error("stored exp %0h got %0h", exp_r.stored, got.stored); errors++;
          end
          if (got.stored_seq !== exp_r.stored_seq) begin
            $error("stored_seq exp %0h got %0h", exp_r.stored_seq, got.stored_seq); errors++;
          end
          if (got.coarse_mode !== exp_r.coarse_mode) begin
            $error("coarse_mode exp %0h got %0h", exp_r.coarse_mode, got.coarse_mode);
            errors++;
          end
          if (got.entry_count !== exp_r.entry_count) begin
            $error("entry_count exp %0h got %0h", exp_r.entry_count, got.entry_count);
            errors++;
          end
          if (got.read_valid !== exp_r.read_valid) begin
            $error("read_valid exp %0h got %0h", exp_r.read_valid, got.read_valid); errors++;
          end
          if (got.read_seq !== exp_r.read_seq) begin
            $error("read_seq exp %0h got %0h", exp_r.read_seq, got.read_seq); errors++;
          end
          if (got.read_time_ms !== exp_r.read_time_ms) begin
            $error("read_time_ms exp %0h got %0h", exp_r.read_time_ms, got.read_time_ms);
            errors++;
          end
          if (got.read_data !== exp_r.read_data) begin
            $error("read_data exp %0h got %0h", exp_r.read_data, got.read_data); errors++;
          end
        end
      end
      out_ch.ready <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // hold off the receiver for a long stretch once requested
  initial begin
    wait (hold_go);
    hold_recv = 1'b1;
    repeat (400) @(posedge clk);
    hold_recv = 1'b0;
    hold_done = 1'b1;
  end

  // watchdog
  int quiet_cycles;
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic add_tick(input logic [31:0] now, input logic [31:0] seen,
                          input logic [63:0] data);
    tb_trd_types::tick_item_t it;
    it.func = trd_pkg::FUNC_TICK;
    it.now_ms = now;
    it.client_seen_ms = seen;
    it.record_data = data;
    it.read_index = 10'($urandom());
    pending_items.push_back(it);
    in_flight_items++;
  endtask

  task automatic add_read(input logic [9:0] idx);
    tb_trd_types::tick_item_t it;
    it.func = trd_pkg::FUNC_READ;
    it.now_ms = $urandom();
    it.client_seen_ms = $urandom();
    it.record_data = rand64();
    it.read_index = idx;
    pending_items.push_back(it);
    in_flight_items++;
  endtask

  task automatic drain();
    wait (pending_items.size() == 0 && in_flight_items == 0 && expected_results.size() == 0);
    repeat (RING_DEPTH * 3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [trd_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      trd_pkg::CFG_FINE_INTERVAL: fine_ms = val[15:0];
      trd_pkg::CFG_COARSE_STRIDE: stride_reg = val[4:0];
      trd_pkg::CFG_ABSENCE_LIMIT: absent_limit = val;
      default: ;
    endcase
  endtask

  function automatic int unsigned rec_count_guess();
    return (rec_count == 0) ? 3 : rec_count + 2;
  endfunction

  // present client phase, long absence, then contact again; reads interleaved
  task automatic random_session(input int n);
    int unsigned step;
    logic [31:0] seen;
    logic absent_phase;
    absent_phase = 1'b0;
    seen = sim_now;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(9) < 3) begin
        if ($urandom_range(3) == 0) add_read(10'($urandom()));
        else add_read(10'($urandom_range(rec_count_guess())));
      end else begin
        step = (fine_ms == 0) ? $urandom_range(5) : $urandom_range(2 * fine_ms + 2);
        if ($urandom_range(40) == 0) step = $urandom();
        sim_now = sim_now + step;
        if ($urandom_range(30) == 0) absent_phase = ~absent_phase;
        if (!absent_phase) seen = sim_now - $urandom_range(3);
        else if ($urandom_range(20) == 0) seen = sim_now - absent_limit - 1;
        add_tick(sim_now, ($urandom_range(50) == 0) ? $urandom() : seen, rand64());
      end
    end
  endtask

  initial begin
    send_idle_pct = 10;
    recv_idle_pct = 48;
    cfg_we = 1'b0;
    cfg_idx = trd_pkg::CFG_FINE_INTERVAL;
    cfg_wdata = '0;
    wr_slot = 0;
    rec_count = 0;
    seq_next_base = 0;
    last_cap = 0;
    coarse_on = 1'b0;
    fine_ms = trd_pkg::FINE_INTERVAL_RST;
    stride_reg = trd_pkg::COARSE_STRIDE_RST;
    absent_limit = trd_pkg::ABSENCE_LIMIT_RST;
    sim_now = 0;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset settings
    add_read(10'd0);
    add_tick(32'd0, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    add_tick(32'd5, 32'd5, 64'h0);
    add_tick(32'd1000, 32'd1000, 64'h0123_4567_89AB_CDEF);
    add_tick(32'd1999, 32'd1999, 64'h1);
    add_tick(32'd3000, 32'd2990, 64'h2);
    add_tick(32'd4000, 32'd0, 64'h3);
    add_read(10'd0);
    add_read(10'd2);
    add_read(10'd3);
    add_read(10'h3FF);
    add_tick(32'd1500000, 32'd0, 64'h4);
    add_read(10'd0);
    add_read(10'd1);
    add_tick(32'd1502000, 32'd0, 64'h5);
    add_tick(32'd1505000, 32'd1505000, 64'h6);
    add_tick(32'hFFFF_FFF0, 32'hFFFF_FFF0, 64'h7);
    add_tick(32'd20, 32'd20, 64'h8);
    add_tick(32'd2000, 32'hFFFF_FFFF, 64'h9);
    add_read(10'd1);
    drain();

    write_reg(trd_pkg::CFG_FINE_INTERVAL, 32'd0);
    write_reg(trd_pkg::CFG_COARSE_STRIDE, 32'd0);
    write_reg(trd_pkg::CFG_ABSENCE_LIMIT, 32'd0);
    write_reg(CFG_IDX_NONE, 32'hFFFF_FFFF);
    sim_now = 32'd100;
    random_session(150);
    drain();

    // fill the ring past depth with a held-off receiver
    write_reg(trd_pkg::CFG_FINE_INTERVAL, 32'd1);
    write_reg(trd_pkg::CFG_COARSE_STRIDE, 32'd16);
    write_reg(trd_pkg::CFG_ABSENCE_LIMIT, 32'hFFFF_FFFF);
    hold_go = 1'b1;
    for (int k = 0; k < 1100; k++) begin
      sim_now = sim_now + 1;
      add_tick(sim_now, sim_now, rand64());
    end
    wait (hold_done);
    add_read(10'd0);
    add_read(10'h3FF);
    drain();
    write_reg(trd_pkg::CFG_ABSENCE_LIMIT, 32'd10);
    add_tick(sim_now + 100, sim_now, 64'hA);
    add_read(10'd63);
    add_read(10'd64);
    drain();

    send_idle_pct = 48;
    recv_idle_pct = 10;
    write_reg(trd_pkg::CFG_FINE_INTERVAL, 32'd65535);
    write_reg(trd_pkg::CFG_COARSE_STRIDE, 32'd1);
    write_reg(trd_pkg::CFG_ABSENCE_LIMIT, 32'd200000);
    random_session(100);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(trd_pkg::CFG_FINE_INTERVAL, 32'd7);
    write_reg(trd_pkg::CFG_COARSE_STRIDE, 32'd3);
    write_reg(trd_pkg::CFG_ABSENCE_LIMIT, 32'd40);
    random_session(175);
    drain();

    write_reg(trd_pkg::CFG_COARSE_STRIDE, 32'd31);
    write_reg(trd_pkg::CFG_ABSENCE_LIMIT, 32'd60);
    random_session(100);
    drain();

    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule
